// File: src/rwfb_pkg.sv
// Shared types, constants and helpers for the range window frame bounds unit.
package rwfb_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int ROW_W    = $clog2(MAX_ROWS);   // row index
    localparam int CNT_W    = ROW_W + 1;          // counts up to MAX_ROWS
    localparam int KEY_W    = 32;
    localparam int SUM_W    = KEY_W + 1;          // exact key + offset
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CNT_W;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NULLS_FIRST     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_COUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_UNBOUNDED  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_UNBOUNDED = 2'd3;

    typedef struct packed {
        logic             nulls_first;
        logic [CNT_W-1:0] null_count;
        logic             left_unbounded;
        logic             right_unbounded;
        logic [CNT_W-1:0] row_count;
    } t_part_cfg;

    // midpoint of [lo, hi), lo <= hi
    function automatic logic [CNT_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                                input logic [CNT_W-1:0] hi);
        logic [CNT_W-1:0] span;
        span = hi - lo;
        return lo + (span >> 1);
    endfunction

endpackage

// File: src/rwfb_key_ram.sv
// Key store: single write port, single read port, registered read data.
module rwfb_key_ram
    import rwfb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ROW_W-1:0] i_waddr,
    input  logic [KEY_W-1:0] i_wdata,
    input  logic [ROW_W-1:0] i_raddr,
    output logic [KEY_W-1:0] o_rdata
);

    logic [KEY_W-1:0] r_mem [MAX_ROWS];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/rwfb_search.sv
// Query sequencer: row key fetch, then up to two binary searches over the key store.
module rwfb_search
    import rwfb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_query,
    input  logic [ROW_W-1:0] i_row,
    input  logic [KEY_W-1:0] i_left_offset,
    input  logic [KEY_W-1:0] i_right_offset,
    input  t_part_cfg        i_cfg,
    input  logic [KEY_W-1:0] i_rdata,
    output logic [ROW_W-1:0] o_raddr,
    output logic             o_busy,
    output logic             o_result_valid,
    output logic [CNT_W-1:0] o_first_row,
    output logic [CNT_W-1:0] o_end_row,
    output logic             o_status
);

    typedef enum logic [1:0] {S_IDLE, S_KEY, S_SRCH} t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_val_lo, n_val_lo, r_val_hi, n_val_hi;
    logic [CNT_W-1:0]        r_lo, n_lo, r_hi, n_hi;
    logic [CNT_W-1:0]        r_begin, n_begin;
    logic                    r_strict, n_strict;
    logic signed [SUM_W-1:0] r_bound, n_bound, r_rbound, n_rbound;
    logic [KEY_W-1:0]        r_loff, n_loff, r_roff, n_roff;
    logic                    r_valid, n_valid, r_status, n_status;
    logic [CNT_W-1:0]        r_fb, n_fb, r_fe, n_fe;
    logic [CNT_W-1:0]        raddr_full;

    logic [CNT_W-1:0]        rc, nc, row_x, null_lo, null_hi, val_lo, val_hi, mid;
    logic signed [SUM_W-1:0] key_x, lb, rb;
    logic                    go_right;

    always_comb begin
        rc    = i_cfg.row_count;
        nc    = (i_cfg.null_count < rc) ? i_cfg.null_count : rc;
        row_x = {1'b0, i_row};
        if (i_cfg.nulls_first) begin
            null_lo = '0;
            null_hi = nc;
            val_lo  = nc;
            val_hi  = rc;
        end else begin
            null_lo = rc - nc;
            null_hi = rc;
            val_lo  = '0;
            val_hi  = rc - nc;
        end
        key_x    = SUM_W'(signed'(i_rdata));
        lb       = key_x + SUM_W'(signed'(r_loff));
        rb       = key_x + SUM_W'(signed'(r_roff));
        mid      = mid_of(r_lo, r_hi);
        go_right = r_strict ? (key_x <= r_bound) : (key_x < r_bound);

        n_state  = r_state;
        n_val_lo = r_val_lo;
        n_val_hi = r_val_hi;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_begin  = r_begin;
        n_strict = r_strict;
        n_bound  = r_bound;
        n_rbound = r_rbound;
        n_loff   = r_loff;
        n_roff   = r_roff;
        n_valid  = 1'b0;
        n_status = r_status;
        n_fb     = r_fb;
        n_fe     = r_fe;
        raddr_full = row_x;

        unique case (r_state)
            S_IDLE: begin
                if (i_query) begin
                    if (row_x >= rc) begin
                        n_valid  = 1'b1;
                        n_status = 1'b1;
                        n_fb     = '0;
                        n_fe     = '0;
                    end else if (row_x >= null_lo && row_x < null_hi) begin
                        n_valid  = 1'b1;
                        n_status = 1'b0;
                        n_fb     = null_lo;
                        n_fe     = null_hi;
                    end else begin
                        n_val_lo = val_lo;
                        n_val_hi = val_hi;
                        n_loff   = i_left_offset;
                        n_roff   = i_right_offset;
                        n_state  = S_KEY;
                    end
                end
            end
            S_KEY: begin
                // row key is on the read data now; first probe of either search
                n_rbound   = rb;
                n_lo       = r_val_lo;
                n_hi       = r_val_hi;
                raddr_full = mid_of(r_val_lo, r_val_hi);
                n_begin    = '0;
                if (!i_cfg.left_unbounded) begin
                    n_bound  = lb;
                    n_strict = 1'b0;
                    n_state  = S_SRCH;
                end else if (!i_cfg.right_unbounded) begin
                    n_bound  = rb;
                    n_strict = 1'b1;
                    n_state  = S_SRCH;
                end else begin
                    n_valid  = 1'b1;
                    n_status = 1'b0;
                    n_fb     = '0;
                    n_fe     = rc;
                    n_state  = S_IDLE;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    // read data holds key[mid]
                    if (go_right) begin
                        n_lo = mid + CNT_W'(1);
                    end else begin
                        n_hi = mid;
                    end
                    raddr_full = mid_of(n_lo, n_hi);
                end else if (!r_strict) begin
                    n_begin = r_lo;
                    if (i_cfg.right_unbounded) begin
                        n_valid  = 1'b1;
                        n_status = 1'b0;
                        n_fb     = r_lo;
                        n_fe     = rc;
                        n_state  = S_IDLE;
                    end else begin
                        n_bound    = r_rbound;
                        n_strict   = 1'b1;
                        n_lo       = r_val_lo;
                        n_hi       = r_val_hi;
                        raddr_full = mid_of(r_val_lo, r_val_hi);
                    end
                end else begin
                    n_valid  = 1'b1;
                    n_status = 1'b0;
                    n_fb     = r_begin;
                    n_fe     = r_lo;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_status <= 1'b0;
            r_fb     <= '0;
            r_fe     <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_status <= n_status;
            r_fb     <= n_fb;
            r_fe     <= n_fe;
        end
        r_val_lo <= n_val_lo;
        r_val_hi <= n_val_hi;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_begin  <= n_begin;
        r_strict <= n_strict;
        r_bound  <= n_bound;
        r_rbound <= n_rbound;
        r_loff   <= n_loff;
        r_roff   <= n_roff;
    end

    assign o_raddr        = raddr_full[ROW_W-1:0];
    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_first_row    = r_fb;
    assign o_end_row      = r_fe;
    assign o_status       = r_status;

endmodule

// File: src/range_window_frame_bounds_unit.sv
// Top level of the range window frame bounds unit.
//
//  channel   | transfer when                 | carries
//  ----------+-------------------------------+-------------------------------------------
//  command   | start && !busy                | i_op, i_key, i_last_key, i_row, offsets
//  result    | o_result_valid (one cycle)    | o_first_row, o_end_row, o_status
//  config    | i_cfg_valid && o_cfg_ready    | i_cfg_index, i_cfg_data
//
// A load never raises busy; its key is written at the accepting edge (dropped when full).
// A query that searches holds busy through the row key fetch and the binary searches;
// each step is one read of the key store's read port. Out-of-range and null-row queries
// answer the cycle after accept.
// Reset is synchronous and active low; the key store is not cleared.
// Results cannot be stalled; config is always ready.
module range_window_frame_bounds_unit
    import rwfb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_op,
    input  logic [KEY_W-1:0]      i_key,
    input  logic                  i_last_key,
    input  logic [ROW_W-1:0]      i_row,
    input  logic [KEY_W-1:0]      i_left_offset,
    input  logic [KEY_W-1:0]      i_right_offset,
    output logic                  o_result_valid,
    output logic [CNT_W-1:0]      o_first_row,
    output logic [CNT_W-1:0]      o_end_row,
    output logic                  o_status,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic             r_nulls_first, r_left_unb, r_right_unb;
    logic [CNT_W-1:0] r_null_count, r_row_count, r_load_ptr;
    logic             accept, load_acc, query_acc, load_ok, cfg_wr;
    logic [CNT_W-1:0] ptr_inc;
    logic [ROW_W-1:0] raddr;
    logic [KEY_W-1:0] rdata;
    t_part_cfg        part_cfg;

    assign accept    = start && !busy;
    assign load_acc  = accept && (i_op == OP_LOAD);
    assign query_acc = accept && (i_op == OP_QUERY);
    assign load_ok   = (r_load_ptr != CNT_W'(MAX_ROWS));
    assign ptr_inc   = r_load_ptr + CNT_W'(load_ok);
    assign cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nulls_first <= 1'b1;
            r_null_count  <= '0;
            r_left_unb    <= 1'b0;
            r_right_unb   <= 1'b0;
            r_row_count   <= '0;
            r_load_ptr    <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_NULLS_FIRST:     r_nulls_first <= i_cfg_data[0];
                    CFG_NULL_COUNT:      r_null_count  <= i_cfg_data;
                    CFG_LEFT_UNBOUNDED:  r_left_unb    <= i_cfg_data[0];
                    CFG_RIGHT_UNBOUNDED: r_right_unb   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (load_acc) begin
                if (i_last_key) begin
                    r_row_count <= ptr_inc;
                    r_load_ptr  <= '0;
                end else begin
                    r_load_ptr  <= ptr_inc;
                end
            end
        end
    end

    assign part_cfg = '{nulls_first:     r_nulls_first,
                        null_count:      r_null_count,
                        left_unbounded:  r_left_unb,
                        right_unbounded: r_right_unb,
                        row_count:       r_row_count};

    rwfb_key_ram u_key_ram (
        .i_clk   (i_clk),
        .i_we    (load_acc && load_ok),
        .i_waddr (r_load_ptr[ROW_W-1:0]),
        .i_wdata (i_key),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    rwfb_search u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_query        (query_acc),
        .i_row          (i_row),
        .i_left_offset  (i_left_offset),
        .i_right_offset (i_right_offset),
        .i_cfg          (part_cfg),
        .i_rdata        (rdata),
        .o_raddr        (raddr),
        .o_busy         (busy),
        .o_result_valid (o_result_valid),
        .o_first_row    (o_first_row),
        .o_end_row      (o_end_row),
        .o_status       (o_status)
    );

endmodule

// File: src/rwfb_checker.sv
// Port-level checks for the range window frame bounds unit, bound to the top level.
module rwfb_checker
    import rwfb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             i_op,
    input logic             o_result_valid,
    input logic [CNT_W-1:0] o_first_row,
    input logic [CNT_W-1:0] o_end_row,
    input logic             o_status
);

    // a query transfer either answers at once or starts a search
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_QUERY) |=> (busy || o_result_valid))
        else $error("query transfer neither answered nor raised busy");

    // a load transfer never raises busy
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_LOAD) |=> !busy)
        else $error("load transfer raised busy");

    // results come only out of query work
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(busy) || $past(start && i_op == OP_QUERY)))
        else $error("result without a query in flight");

    // a search always ends with its result
    a_search_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("search ended without a result");

    a_status_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status) |-> (o_first_row == '0 && o_end_row == '0))
        else $error("out-of-range query returned a nonempty frame");

endmodule

bind range_window_frame_bounds_unit rwfb_checker u_rwfb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_op           (i_op),
    .o_result_valid (o_result_valid),
    .o_first_row    (o_first_row),
    .o_end_row      (o_end_row),
    .o_status       (o_status)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the range window frame bounds unit: loads, queries, register settings.
module testbench;
    import rwfb_pkg::*;

    localparam int     SETTLE_CYCLES = 40;    // outlasts a full-size query
    localparam int     QUIET_LIMIT   = 2000;
    localparam int     RANDOM_ITEMS  = 200;
    localparam longint KEY_LO        = -64'sd2147483648;
    localparam longint KEY_HI        = 64'sd2147483647;
    localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct {
        logic             op;
        logic [KEY_W-1:0] key;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [KEY_W-1:0] left_ofs;
        logic [KEY_W-1:0] right_ofs;
    } cmd_t;

    typedef struct {
        logic [CNT_W-1:0] first_row;
        logic [CNT_W-1:0] stop_row;
        logic             status_bit;
    } frame_t;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic                  i_op           = OP_LOAD;
    logic [KEY_W-1:0]      i_key          = '0;
    logic                  i_last_key     = 1'b0;
    logic [ROW_W-1:0]      i_row          = '0;
    logic [KEY_W-1:0]      i_left_offset  = '0;
    logic [KEY_W-1:0]      i_right_offset = '0;
    logic                  o_result_valid;
    logic [CNT_W-1:0]      o_first_row;
    logic [CNT_W-1:0]      o_end_row;
    logic                  o_status;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_NULLS_FIRST;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    range_window_frame_bounds_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_last_key     (i_last_key),
        .i_row          (i_row),
        .i_left_offset  (i_left_offset),
        .i_right_offset (i_right_offset),
        .o_result_valid (o_result_valid),
        .o_first_row    (o_first_row),
        .o_end_row      (o_end_row),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor
    logic signed [KEY_W-1:0] key_mem [0:MAX_ROWS-1];
    logic [CNT_W-1:0]        rows_loaded   = '0;
    logic [CNT_W-1:0]        load_ptr      = '0;
    logic                    nulls_first_r = 1'b1;
    logic [CNT_W-1:0]        null_cnt_r    = '0;
    logic                    left_unb_r    = 1'b0;
    logic                    right_unb_r   = 1'b0;

    frame_t frames_due [$];

    int n_loads    = 0;
    int n_queries  = 0;
    int n_settings = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_pushed   = 0;

    // first row in [lo, hi) whose key is >= bnd (> bnd when strict), same halving as the block
    function automatic logic [CNT_W-1:0] bound_search(input logic [CNT_W-1:0] lo,
                                                     input logic [CNT_W-1:0] hi,
                                                     input longint bnd, input bit strict);
        logic [CNT_W-1:0] mid;
        longint           k;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            k = longint'(key_mem[mid[ROW_W-1:0]]);
            if (strict ? (k <= bnd) : (k < bnd))
                lo = mid + 1'b1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic frame_t frame_of(input cmd_t c);
        frame_t           f;
        logic [CNT_W-1:0] row_w, nc, null_lo, null_hi, val_lo, val_hi;
        longint           k;
        f.first_row  = '0;
        f.stop_row   = '0;
        f.status_bit = 1'b0;
        row_w = {1'b0, c.row};
        if (row_w >= rows_loaded) begin
            f.status_bit = 1'b1;
        end else begin
            nc = (null_cnt_r < rows_loaded) ? null_cnt_r : rows_loaded;
            if (nulls_first_r) begin
                null_lo = '0;
                null_hi = nc;
                val_lo  = nc;
                val_hi  = rows_loaded;
            end else begin
                null_lo = rows_loaded - nc;
                null_hi = rows_loaded;
                val_lo  = '0;
                val_hi  = rows_loaded - nc;
            end
            if (row_w >= null_lo && row_w < null_hi) begin
                f.first_row = null_lo;
                f.stop_row  = null_hi;
            end else begin
                k = longint'(key_mem[c.row]);
                f.first_row = left_unb_r ? '0 :
                    bound_search(val_lo, val_hi, k + longint'($signed(c.left_ofs)), 1'b0);
                f.stop_row = right_unb_r ? rows_loaded :
                    bound_search(val_lo, val_hi, k + longint'($signed(c.right_ofs)), 1'b1);
            end
        end
        return f;
    endfunction

    function automatic void take_command(input cmd_t c);
        if (c.op == OP_LOAD) begin
            // loads past capacity are dropped
            if (load_ptr < MAX_ROWS) begin
                key_mem[load_ptr[ROW_W-1:0]] = c.key;
                load_ptr = load_ptr + 1'b1;
            end
            if (c.last) begin
                rows_loaded = load_ptr;
                load_ptr    = '0;
            end
            n_loads++;
        end else begin
            frames_due.push_back(frame_of(c));
            n_queries++;
        end
    endfunction

    // ---------------------------------------------------------------- driver
    cmd_t cmds_pending [$];
    cmd_t cur_cmd;
    bit   cur_valid = 1'b0;
    bit   no_gaps   = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                take_command(cur_cmd);
                cur_valid = 1'b0;
            end
            if (!cur_valid && cmds_pending.size() != 0) begin
                cur_cmd   = cmds_pending.pop_front();
                cur_valid = 1'b1;
            end
            // gaps may also drop start while busy, so start returns at any point of a search
            if (cur_valid && (no_gaps || $urandom_range(0, 99) >= 10)) begin
                start          <= 1'b1;
                i_op           <= cur_cmd.op;
                i_key          <= cur_cmd.key;
                i_last_key     <= cur_cmd.last;
                i_row          <= cur_cmd.row;
                i_left_offset  <= cur_cmd.left_ofs;
                i_right_offset <= cur_cmd.right_ofs;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- register writes seen
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NULLS_FIRST:     nulls_first_r = i_cfg_data[0];
                CFG_NULL_COUNT:      null_cnt_r    = i_cfg_data;
                CFG_LEFT_UNBOUNDED:  left_unb_r    = i_cfg_data[0];
                CFG_RIGHT_UNBOUNDED: right_unb_r   = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- monitor
    frame_t due_frame;

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (frames_due.size() == 0) begin
                $error("unexpected result: first_row %0d end_row %0d status %0d",
                       o_first_row, o_end_row, o_status);
                n_errors++;
            end else begin
                due_frame = frames_due.pop_front();
                n_checked++;
                if (o_first_row !== due_frame.first_row) begin
                    $error("first_row: expected %0d, got %0d",
                           due_frame.first_row, o_first_row);
                    n_errors++;
                end
                if (o_end_row !== due_frame.stop_row) begin
                    $error("end_row: expected %0d, got %0d",
                           due_frame.stop_row, o_end_row);
                    n_errors++;
                end
                if (o_status !== due_frame.status_bit) begin
                    $error("status: expected %0d, got %0d", due_frame.status_bit, o_status);
                    n_errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus
    // mirror of the key store as the queue will leave it, for choosing rows and offsets
    logic [KEY_W-1:0] gen_keys [0:MAX_ROWS-1];
    int               gen_rows = 0;
    int               gen_ptr  = 0;

    task automatic push_load(input logic [KEY_W-1:0] key, input logic last);
        cmd_t c;
        c.op        = OP_LOAD;
        c.key       = key;
        c.last      = last;
        c.row       = $urandom;
        c.left_ofs  = $urandom;
        c.right_ofs = $urandom;
        if (gen_ptr < MAX_ROWS) begin
            gen_keys[gen_ptr] = key;
            gen_ptr++;
        end
        if (last) begin
            gen_rows = gen_ptr;
            gen_ptr  = 0;
        end
        cmds_pending.push_back(c);
        n_pushed++;
    endtask

    task automatic push_query(input logic [ROW_W-1:0] row, input logic [KEY_W-1:0] left_ofs,
                              input logic [KEY_W-1:0] right_ofs);
        cmd_t c;
        c.op        = OP_QUERY;
        c.key       = $urandom;
        c.last      = $urandom_range(0, 1);
        c.row       = row;
        c.left_ofs  = left_ofs;
        c.right_ofs = right_ofs;
        cmds_pending.push_back(c);
        n_pushed++;
    endtask

    function automatic int pick_row();
        int r;
        r = $urandom_range(0, 99);
        if (gen_rows != 0 && r < 75)
            return $urandom_range(0, gen_rows - 1);
        if (gen_rows < MAX_ROWS && r < 88)
            return $urandom_range(gen_rows, MAX_ROWS - 1);
        return $urandom_range(0, MAX_ROWS - 1);
    endfunction

    function automatic logic [KEY_W-1:0] pick_offset(input int row);
        int r, other, d;
        r = $urandom_range(0, 9);
        d = $urandom_range(0, 16);
        if (r <= 3)
            return d - 8;
        if (r <= 5 && row < gen_rows) begin
            // land on or next to another row's key: equality at the bound
            other = $urandom_range(0, gen_rows - 1);
            d = $urandom_range(0, 2);
            return gen_keys[other] - gen_keys[row] + (d - 1);
        end
        if (r == 6)
            return $urandom;
        if (r == 7)
            return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
        d = $urandom_range(0, 2000);
        return d - 1000;
    endfunction

    task automatic push_random_query();
        int row;
        row = pick_row();
        push_query(row, pick_offset(row), pick_offset(row));
    endtask

    task automatic load_partition(input int n, input int style, input bit mark_last);
        longint           k, stride;
        logic [31:0]      step_max;
        logic [KEY_W-1:0] key;
        int               r;
        stride   = 64'sd4294967295 / (n + 1);
        step_max = (stride * 2 > 64'sd4294967295) ? 32'hFFFF_FFFF : 32'(stride * 2);
        r = $urandom;
        case (style)
            0:       begin r = $urandom_range(0, 40); k = r - 20; end
            1:       k = KEY_LO + $urandom_range(0, 1000);
            default: k = r;
        endcase
        for (int i = 0; i < n; i++) begin
            if (style == 2)
                key = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 7);
            else
                key = k[KEY_W-1:0];
            push_load(key, mark_last && i == n - 1);
            case (style)
                0:       k = k + $urandom_range(0, 2);
                1:       k = k + $urandom_range(0, step_max);
                default: k = k + $urandom_range(0, 1000);
            endcase
            if (k > KEY_HI)
                k = KEY_HI;
            // queries now and then in the middle of a load sequence
            if ($urandom_range(0, 99) < 6)
                push_random_query();
        end
    endtask

    task automatic wait_drained();
        while (cmds_pending.size() != 0 || cur_valid || frames_due.size() != 0)
            @(posedge i_clk);
        // the last load or search may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // one-bit registers get random upper data bits, only bit 0 counts
    task automatic set_regs(input logic nf, input logic [CFG_DATA_W-1:0] nc,
                            input logic lu, input logic ru);
        logic [CFG_DATA_W-1:0] d;
        d = $urandom;
        d[0] = nf;
        write_reg(CFG_NULLS_FIRST, d);
        write_reg(CFG_NULL_COUNT, nc);
        d = $urandom;
        d[0] = lu;
        write_reg(CFG_LEFT_UNBOUNDED, d);
        d = $urandom;
        d[0] = ru;
        write_reg(CFG_RIGHT_UNBOUNDED, d);
        n_settings++;
    endtask

    task automatic random_setting();
        int nc;
        case ($urandom_range(0, 7))
            0:       nc = 0;
            1:       nc = 1;
            2:       nc = gen_rows;
            3, 4:    nc = $urandom_range(0, gen_rows);
            5:       nc = gen_rows + $urandom_range(1, 20);
            6:       nc = MAX_ROWS;
            default: nc = MAX_ROWS - 1;
        endcase
        if (nc > MAX_ROWS)
            nc = MAX_ROWS;
        set_regs($urandom_range(0, 1), nc, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    endtask

    initial begin
        int base, n, r, style, phase_no;
        phase_no = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // nothing loaded yet: every row is out of range
        push_query(0, 0, 0);
        push_query(MAX_ROWS - 1, KEY_MAX, KEY_MIN);
        // extreme keys, sums beyond the key range on both sides
        push_load(KEY_MIN, 1'b0);
        push_load(-5, 1'b0);
        push_load(7, 1'b0);
        push_load(KEY_MAX, 1'b1);
        push_query(0, KEY_MIN, KEY_MAX);
        push_query(3, KEY_MAX, KEY_MIN);
        push_query(2, -12, 0);
        push_query(1, 0, 0);
        push_query(4, 0, 0);
        wait_drained();
        set_regs(1'b1, 1, 1'b1, 1'b0);
        push_query(0, 0, 0);
        push_query(2, 5, 5);
        wait_drained();
        set_regs(1'b0, 2, 1'b0, 1'b1);
        push_query(3, 0, 0);
        push_query(2, 0, 0);
        push_query(0, -3, 1);
        wait_drained();
        // null count above the row count: whole partition is null
        set_regs(1'b1, MAX_ROWS, 1'b0, 1'b0);
        push_query(1, 0, 0);
        wait_drained();
        set_regs(1'b0, 0, 1'b1, 1'b1);
        push_query(1, 0, 0);
        push_load(0, 1'b1);
        push_query(0, 0, 0);

        // full capacity, with a few loads past the end that must be dropped
        wait_drained();
        no_gaps = 1'b1;
        load_partition(MAX_ROWS + 3, 1, 1'b1);
        wait_drained();
        no_gaps = 1'b0;
        for (int s = 0; s < 3; s++) begin
            case (s)
                0:       set_regs(1'b1, 0, 1'b0, 1'b0);
                1:       set_regs(1'b0, 700, 1'b1, 1'b0);
                default: set_regs(1'b1, 300, 1'b0, 1'b1);
            endcase
            repeat (30) push_random_query();
            wait_drained();
        end

        base = n_pushed;
        while (n_pushed - base < RANDOM_ITEMS) begin
            phase_no++;
            no_gaps = (phase_no % 9 == 4);
            r = $urandom_range(0, 99);
            n = (r < 80) ? $urandom_range(1, 16) :
                (r < 97) ? $urandom_range(17, 64) : $urandom_range(65, 200);
            r = $urandom_range(0, 99);
            style = (r < 35) ? 0 : (r < 60) ? 1 : (r < 85) ? 3 : 2;
            // now and then a sequence is left open and the next one continues it
            load_partition(n, style, $urandom_range(0, 9) != 0);
            wait_drained();
            random_setting();
            repeat ($urandom_range(6, 20)) push_random_query();
        end
        wait_drained();

        $display("Covered %0d loads and %0d queries over %0d register settings; %0d frames checked.",
                 n_loads, n_queries, n_settings, n_checked);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
